// ===== src/mfmd_pkg.sv =====
// Package for the motor feedback multi-turn decoder.
// Holds the frame constants, the queue sizing and the item type passed from front to back.
// No dependencies.
package mfmd_pkg;

    localparam int unsigned DEG_PER_TURN       = 360;
    localparam int unsigned ANGLE_PER_TURN_Q16 = 23592960;
    localparam int unsigned COUNTS_PER_TURN    = 65535;
    localparam int          WRAP_STEP          = 32768;

    localparam int unsigned ANGLE_W  = 57;
    localparam int unsigned SCALED_W = 47;
    localparam int unsigned GAIN_W   = 32;

    localparam logic signed [GAIN_W-1:0] SPEED_GAIN_RESET = 32'sd10923;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [7:0]  temperature;
        logic signed [15:0] torque_current;
        logic signed [15:0] rot_speed;
        logic [15:0]        encoder_count;
        logic signed [31:0] turn_count;
    } frame_t;

endpackage

// ===== src/mfmd_if.sv =====
// Handshake interfaces for the decoder's frame input and result output.
// Uses the widths from mfmd_pkg.
interface mfmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] temp_byte;
    logic [7:0] torque_low;
    logic [7:0] torque_high;
    logic [7:0] speed_low;
    logic [7:0] speed_high;
    logic [7:0] enc_low;
    logic [7:0] enc_high;

    modport source (
        output valid, temp_byte, torque_low, torque_high, speed_low, speed_high,
               enc_low, enc_high,
        input  ready
    );
    modport sink (
        input  valid, temp_byte, torque_low, torque_high, speed_low, speed_high,
               enc_low, enc_high,
        output ready
    );
endinterface

interface mfmd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [7:0]                    temperature;
    logic signed [15:0]                   torque_current;
    logic signed [15:0]                   rot_speed;
    logic [15:0]                          encoder_count;
    logic signed [31:0]                   turn_count;
    logic signed [mfmd_pkg::ANGLE_W-1:0]  multi_angle_q16;
    logic signed [mfmd_pkg::SCALED_W-1:0] speed_scaled_q16;

    modport source (
        output valid, temperature, torque_current, rot_speed, encoder_count, turn_count,
               multi_angle_q16, speed_scaled_q16,
        input  ready
    );
    modport sink (
        input  valid, temperature, torque_current, rot_speed, encoder_count, turn_count,
               multi_angle_q16, speed_scaled_q16,
        output ready
    );
endinterface

// ===== src/mfmd_front.sv =====
// Front end: accepts frames, unpacks the fields and tracks encoder wraps into the turn count.
// Depends on mfmd_pkg and mfmd_in_if.
module mfmd_front (
    input  logic             clk,
    input  logic             rst_n,
    mfmd_in_if.sink          frame,
    input  logic             q_full,
    output logic             q_push,
    output mfmd_pkg::frame_t q_data
);

    logic               seen_reg;
    logic [15:0]        prev_reg;
    logic signed [31:0] turns_reg;
    logic signed [31:0] turns_next;
    logic [15:0]        raw;
    logic signed [16:0] diff;

    assign raw         = {frame.enc_high, frame.enc_low};
    assign diff        = $signed({1'b0, raw}) - $signed({1'b0, prev_reg});
    assign frame.ready = !q_full;
    assign q_push      = frame.valid && !q_full;

    always_comb
    begin
        turns_next = turns_reg;
        priority if (!seen_reg)
        begin
            turns_next = '0;
        end
        else if (diff > 17'(mfmd_pkg::WRAP_STEP))
        begin
            turns_next = turns_reg - 32'sd1;
        end
        else if (diff < -17'(mfmd_pkg::WRAP_STEP))
        begin
            turns_next = turns_reg + 32'sd1;
        end
    end

    always_comb
    begin
        q_data.temperature    = $signed(frame.temp_byte);
        q_data.torque_current = $signed({frame.torque_high, frame.torque_low});
        q_data.rot_speed      = $signed({frame.speed_high, frame.speed_low});
        q_data.encoder_count  = raw;
        q_data.turn_count     = turns_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            prev_reg  <= '0;
            turns_reg <= '0;
        end
        else if (q_push)
        begin
            seen_reg  <= 1'b1;
            prev_reg  <= raw;
            turns_reg <= turns_next;
        end
    end

endmodule

// ===== src/mfmd_queue.sv =====
// Two-entry queue that decouples the front end from the arithmetic back end.
// Depends on mfmd_pkg.
module mfmd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mfmd_pkg::frame_t wdata,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output mfmd_pkg::frame_t rdata
);

    mfmd_pkg::frame_t                   entry_reg [mfmd_pkg::QUEUE_DEPTH];
    logic [mfmd_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [mfmd_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [mfmd_pkg::QUEUE_CW-1:0]      count_reg;
    logic [mfmd_pkg::QUEUE_CW-1:0]      count_next;

    assign full  = (count_reg == mfmd_pkg::QUEUE_CW'(mfmd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/mfmd_back.sv =====
// Back end: computes the multi-turn angle and the scaled speed and holds the result register.
// Depends on mfmd_pkg and mfmd_out_if.
module mfmd_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  mfmd_pkg::frame_t                     q_data,
    output logic                                 q_pop,
    input  logic signed [mfmd_pkg::GAIN_W-1:0]   gain,
    mfmd_out_if.source                           result
);

    logic [24:0]                          deg_raw;
    logic [8:0]                           quot;
    logic [16:0]                          rem;
    logic [8:0]                           quot_fixed;
    logic [24:0]                          frac;
    logic signed [40:0]                   turn_deg;
    logic signed [mfmd_pkg::ANGLE_W-1:0]  angle;
    logic signed [47:0]                   product;

    logic                                 valid_reg;
    mfmd_pkg::frame_t                     item_reg;
    logic signed [mfmd_pkg::ANGLE_W-1:0]  angle_reg;
    logic signed [mfmd_pkg::SCALED_W-1:0] scaled_reg;

    // The fraction of a turn is raw*360*65536/65535, written as p + floor(p/65535)
    // with p = raw*360.
    assign deg_raw    = 25'(q_data.encoder_count) * 25'(mfmd_pkg::DEG_PER_TURN);
    assign quot       = deg_raw[24:16];
    assign rem        = {1'b0, deg_raw[15:0]} + {8'b0, quot};
    assign quot_fixed = (rem >= 17'(mfmd_pkg::COUNTS_PER_TURN)) ? quot + 9'd1 : quot;
    assign frac       = deg_raw + 25'(quot_fixed);

    assign turn_deg = 41'(q_data.turn_count) * 41'sd360;
    assign angle    = $signed({turn_deg, 16'b0}) + $signed({32'b0, frac});
    assign product  = 48'(q_data.rot_speed) * 48'(gain);

    assign q_pop = !q_empty && (!valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg   <= q_data;
            angle_reg  <= angle;
            scaled_reg <= product[mfmd_pkg::SCALED_W-1:0];
        end
    end

    assign result.valid            = valid_reg;
    assign result.temperature      = item_reg.temperature;
    assign result.torque_current   = item_reg.torque_current;
    assign result.rot_speed        = item_reg.rot_speed;
    assign result.encoder_count    = item_reg.encoder_count;
    assign result.turn_count       = item_reg.turn_count;
    assign result.multi_angle_q16  = angle_reg;
    assign result.speed_scaled_q16 = scaled_reg;

endmodule

// ===== src/motor_feedback_multiturn_decoder.sv =====
// Top level of the motor feedback multi-turn decoder.
// Depends on mfmd_pkg, mfmd_if, mfmd_front, mfmd_queue and mfmd_back.
//
// The frame channel takes bytes 1 to 7 of one feedback frame as an item; the result
// channel returns one item per frame with the unpacked fields, the turn count, the
// multi-turn angle in Q16 degrees and the speed scaled by the gain register.
// An accepted frame is written into the queue, and the back end takes it from the
// queue into the output register. One item can be accepted on every cycle while
// the queue is not full; the front end tracks turns, and the back end does two
// constant multiplies for the angle and one 16 by 32 bit multiply for the speed.
// A two-entry queue separates the two halves, and the result is held in an output
// register. When the receiver stalls, the result holds, the queue fills and frame
// ready drops once both queue entries are taken.
// Reset clears the turn tracking, so the first frame after reset sets the turn count
// to zero, and loads the gain with its default of 10923. The gain must be written
// via cfg_we and cfg_data only while no item is in flight, unchecked by the block.
module motor_feedback_multiturn_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    mfmd_in_if.sink                            frame,
    mfmd_out_if.source                         result,
    input  logic                               cfg_we,
    input  logic signed [mfmd_pkg::GAIN_W-1:0] cfg_data
);

    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_empty;
    mfmd_pkg::frame_t                   q_wdata;
    mfmd_pkg::frame_t                   q_rdata;
    logic signed [mfmd_pkg::GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= mfmd_pkg::SPEED_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            gain_reg <= cfg_data;
        end
    end

    mfmd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    mfmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    mfmd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .gain    (gain_reg),
        .result  (result)
    );

endmodule

// ===== src/mfmd_checker.sv =====
// Port-level checks for the motor feedback multi-turn decoder, with the bind that attaches them.
// Depends on mfmd_pkg and on the ports of motor_feedback_multiturn_decoder.
module mfmd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [31:0]                  turn_count,
    input logic signed [mfmd_pkg::ANGLE_W-1:0] angle_q16
);

    logic [2:0]         pending_reg;
    logic [31:0]        last_turn_reg;
    logic               have_turn_reg;
    logic signed [57:0] in_turn;
    logic [31:0]        turn_step;

    assign in_turn   = 58'(angle_q16) - 58'(turn_count) * 58'sd23592960;
    assign turn_step = turn_count - last_turn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            last_turn_reg <= '0;
            have_turn_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
            if (out_valid && out_ready)
            begin
                last_turn_reg <= turn_count;
                have_turn_reg <= 1'b1;
            end
        end
    end

    // A stalled result must not change under the receiver.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_q16) && $stable(turn_count))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result shown with no frame outstanding");

    a_angle_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_turn >= 58'sd0 && in_turn <= 58'sd23592960)
        else $error("angle does not agree with turn count");

    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && have_turn_reg |->
            turn_step == 32'd0 || turn_step == 32'd1 || turn_step == 32'hFFFF_FFFF)
        else $error("turn count moved by more than one between items");

endmodule

bind motor_feedback_multiturn_decoder mfmd_checker u_mfmd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (frame.valid),
    .in_ready   (frame.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .turn_count (result.turn_count),
    .angle_q16  (result.multi_angle_q16)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for motor_feedback_multiturn_decoder.
// Drives feedback frames through mfmd_in_if, checks every result item from mfmd_out_if against
// an in-bench model of the decoder, and depends on mfmd_pkg and the interface file.
module tb_top;

    typedef struct {
        logic [7:0]                    temperature;
        logic [15:0]                   torque_current;
        logic [15:0]                   rot_speed;
        logic [15:0]                   encoder_count;
        logic [31:0]                   turn_count;
        logic [mfmd_pkg::ANGLE_W-1:0]  multi_angle_q16;
        logic [mfmd_pkg::SCALED_W-1:0] speed_scaled_q16;
    } feedback_result_t;

    class decoder_scoreboard;
        feedback_result_t                   frames_due[$];
        logic signed [mfmd_pkg::GAIN_W-1:0] gain = mfmd_pkg::SPEED_GAIN_RESET;
        logic                               tracking = 1'b0;
        logic [15:0]                        last_count = 16'd0;
        logic signed [31:0]                 turns = 32'sd0;
        int                                 errors = 0;
        int                                 checked = 0;

        function void set_gain(logic signed [mfmd_pkg::GAIN_W-1:0] value);
            gain = value;
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        function void note_frame(logic [7:0] temp, logic [15:0] torque, logic [15:0] speed,
                                 logic [15:0] count);
            feedback_result_t   r;
            logic signed [31:0] step;
            logic signed [15:0] speed_s;
            longint             frac;
            longint             angle;
            longint             scaled;
            if (!tracking)
            begin
                turns = 32'sd0;
                tracking = 1'b1;
            end
            else
            begin
                step = $signed({16'd0, count}) - $signed({16'd0, last_count});
                if (step > mfmd_pkg::WRAP_STEP)
                    turns = turns - 32'sd1;
                else if (step < -mfmd_pkg::WRAP_STEP)
                    turns = turns + 32'sd1;
            end
            last_count = count;
            speed_s = speed;
            frac = longint'(count) * longint'(mfmd_pkg::ANGLE_PER_TURN_Q16)
                   / longint'(mfmd_pkg::COUNTS_PER_TURN);
            angle = longint'(turns) * longint'(mfmd_pkg::ANGLE_PER_TURN_Q16) + frac;
            scaled = longint'(speed_s) * longint'(gain);
            r.temperature = temp;
            r.torque_current = torque;
            r.rot_speed = speed;
            r.encoder_count = count;
            r.turn_count = turns;
            r.multi_angle_q16 = angle[mfmd_pkg::ANGLE_W-1:0];
            r.speed_scaled_q16 = scaled[mfmd_pkg::SCALED_W-1:0];
            frames_due.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
        endtask

        task check_result(feedback_result_t got);
            feedback_result_t want;
            if (frames_due.size() == 0)
            begin
                report_mismatch("result item with no frame outstanding");
                return;
            end
            want = frames_due.pop_front();
            checked++;
            compare_field("temperature", 64'(got.temperature), 64'(want.temperature));
            compare_field("torque_current", 64'(got.torque_current), 64'(want.torque_current));
            compare_field("rot_speed", 64'(got.rot_speed), 64'(want.rot_speed));
            compare_field("encoder_count", 64'(got.encoder_count), 64'(want.encoder_count));
            compare_field("turn_count", 64'(got.turn_count), 64'(want.turn_count));
            compare_field("multi_angle_q16", 64'(got.multi_angle_q16),
                          64'(want.multi_angle_q16));
            compare_field("speed_scaled_q16", 64'(got.speed_scaled_q16),
                          64'(want.speed_scaled_q16));
        endtask
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic signed [mfmd_pkg::GAIN_W-1:0] cfg_data;

    mfmd_in_if  frame_ch();
    mfmd_out_if result_ch();

    motor_feedback_multiturn_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame    (frame_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    decoder_scoreboard sb = new;

    int unsigned src_idle_pct = 28;
    int unsigned snk_idle_pct = 74;
    logic [15:0] enc_track = 16'd0;
    int          frames_sent = 0;
    int          gain_settings = 1;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #3_000_000;
        $display("Timed out with %0d result items outstanding.", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin : result_side
        feedback_result_t got;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.temperature = result_ch.temperature;
                got.torque_current = result_ch.torque_current;
                got.rot_speed = result_ch.rot_speed;
                got.encoder_count = result_ch.encoder_count;
                got.turn_count = result_ch.turn_count;
                got.multi_angle_q16 = result_ch.multi_angle_q16;
                got.speed_scaled_q16 = result_ch.speed_scaled_q16;
                sb.check_result(got);
            end
            result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task send_fields(logic [7:0] temp, logic [15:0] torque, logic [15:0] speed,
                     logic [15:0] count);
        while ($urandom_range(99) < src_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.temp_byte <= temp;
        frame_ch.torque_low <= torque[7:0];
        frame_ch.torque_high <= torque[15:8];
        frame_ch.speed_low <= speed[7:0];
        frame_ch.speed_high <= speed[15:8];
        frame_ch.enc_low <= count[7:0];
        frame_ch.enc_high <= count[15:8];
        do
            @(posedge clk);
        while (frame_ch.ready !== 1'b1);
        sb.note_frame(temp, torque, speed, count);
        enc_track = count;
        frames_sent++;
    endtask

    task send_random_frame();
        int unsigned pick;
        int          step;
        logic [15:0] count;
        pick = $urandom_range(99);
        if (pick < 65)
            step = int'($urandom_range(6000)) - 3000;
        else if (pick < 85)
            step = ($urandom_range(1) == 1 ? 1 : -1) * (32760 + int'($urandom_range(16)));
        else
            step = int'($urandom_range(65535));
        count = enc_track + step[15:0];
        send_fields(8'($urandom), 16'($urandom), 16'($urandom), count);
    endtask

    task drain_results();
        frame_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_gain(logic signed [mfmd_pkg::GAIN_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_gain(value);
        gain_settings++;
    endtask

    int unsigned                        seg_items[4] = '{320, 320, 160, 150};
    int unsigned                        seg_src_idle[4] = '{28, 74, 0, 0};
    int unsigned                        seg_snk_idle[4] = '{74, 28, 0, 0};
    logic signed [mfmd_pkg::GAIN_W-1:0] seg_gain[4];
    logic [15:0]                        climb[8] = '{16'd0, 16'd40000, 16'd10000, 16'd50000,
                                                     16'd20000, 16'd60000, 16'd30000,
                                                     16'd65000};

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        frame_ch.valid <= 1'b0;
        frame_ch.temp_byte <= 8'd0;
        frame_ch.torque_low <= 8'd0;
        frame_ch.torque_high <= 8'd0;
        frame_ch.speed_low <= 8'd0;
        frame_ch.speed_high <= 8'd0;
        frame_ch.enc_low <= 8'd0;
        frame_ch.enc_high <= 8'd0;
        seg_gain[0] = 32'sh8000_0000;
        seg_gain[1] = 32'sh7FFF_FFFF;
        seg_gain[2] = 32'sd0;
        seg_gain[3] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first frame only latches the count; the rest walk the wrap thresholds.
        send_fields(8'h80, 16'h8000, 16'h8000, 16'd40000);
        send_fields(8'h7F, 16'h7FFF, 16'h7FFF, 16'd0);
        send_fields(8'hFF, 16'hFFFF, 16'hFFFF, 16'd32768);
        send_fields(8'h00, 16'h0000, 16'h0000, 16'd0);
        send_fields(8'h01, 16'h0001, 16'h0001, 16'd32769);
        send_fields(8'hFE, 16'hFFFE, 16'hFFFE, 16'd0);
        send_fields(8'h7F, 16'h8000, 16'h7FFF, 16'd65535);
        send_fields(8'h80, 16'h7FFF, 16'h8000, 16'd65535);
        send_fields(8'h55, 16'h5555, 16'hAAAA, 16'd0);
        send_fields(8'hAA, 16'hAAAA, 16'h5555, 16'd65535);
        send_fields(8'h00, 16'h8000, 16'h8000, 16'd32767);
        send_fields(8'hFF, 16'h7FFF, 16'h7FFF, 16'd65535);
        send_fields(8'h80, 16'h0000, 16'hFFFF, 16'd32766);
        send_fields(8'h7F, 16'hFFFF, 16'h0000, 16'd1);
        send_fields(8'h01, 16'h0001, 16'h8001, 16'd65534);
        foreach (climb[i])
            send_fields(8'($urandom), 16'($urandom), 16'($urandom), climb[i]);
        drain_results();

        for (int s = 0; s < 4; s++)
        begin
            src_idle_pct = seg_src_idle[s];
            snk_idle_pct = seg_snk_idle[s];
            write_gain(seg_gain[s]);
            for (int n = 0; n < seg_items[s]; n++)
            begin
                if (n == 100)
                    drain_results();
                send_random_frame();
            end
            drain_results();
        end

        write_gain(mfmd_pkg::SPEED_GAIN_RESET);
        send_fields(8'h80, 16'h8000, 16'h8000, enc_track);
        send_fields(8'h7F, 16'h7FFF, 16'h7FFF, enc_track + 16'd1);
        drain_results();
        repeat (10) @(posedge clk);

        $display("Sent %0d frames under %0d gain settings, checked %0d result items.",
                 frames_sent, gain_settings, sb.checked);
        $display("Idle mixes: sender-heavy, receiver-heavy and none; %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
